[hdl/i2cmt_pkg.sv]
`timescale 1ns / 1ps

package i2cmt_pkg;

    localparam int          BUFFER_BYTES_DEF = 16;
    localparam int          INDEX_SPAN       = 16;
    localparam int          BITS_PER_BYTE    = 8;
    localparam logic [7:0]  TICKS_RESET      = 8'd16;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_LOAD  = 2'd1,
        ACT_WRITE = 2'd2,
        ACT_READ  = 2'd3
    } t_action;

    // one input beat
    typedef struct packed {
        logic [1:0] action;
        logic [3:0] buffer_index;
        logic [7:0] byte_value;
        logic [6:0] slave_address;
        logic [4:0] transfer_length;
        logic       sda_sample;
    } t_item;

    // one result beat
    typedef struct packed {
        logic       scl_release;
        logic       sda_release;
        logic       busy_res;
        logic       transfer_done;
        logic       nack_flag;
        logic       read_valid;
        logic [3:0] read_index;
        logic [7:0] read_byte;
    } t_result;

    // byte buffer write request from the sequencer
    typedef struct packed {
        logic       en;
        logic [3:0] slot;
        logic [7:0] data;
    } t_buf_wr;

endpackage

[hdl/i2cmt_buffer.sv]
`timescale 1ns / 1ps

module i2cmt_buffer #(
    parameter int BUFFER_BYTES = i2cmt_pkg::BUFFER_BYTES_DEF
) (
    input  logic                i_clk,
    input  i2cmt_pkg::t_buf_wr  i_wr,
    input  logic [4:0]          i_rd_pos,
    output logic [7:0]          o_rd_data
);
    import i2cmt_pkg::*;

    localparam int AW = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;

    logic [7:0]    r_mem [BUFFER_BYTES];
    logic [7:0]    r_rd_data;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;

    assign wr_addr   = AW'(i_wr.slot);
    assign rd_addr   = AW'(i_rd_pos);
    assign o_rd_data = r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[wr_addr] <= i_wr.data;
        end
    end

    // registered read with write-first bypass, so the data always matches
    // the memory contents after the previous edge
    always_ff @(posedge i_clk) begin
        if (i_wr.en && (wr_addr == rd_addr)) begin
            r_rd_data <= i_wr.data;
        end else begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

endmodule

[hdl/i2cmt_seq.sv]
`timescale 1ns / 1ps

module i2cmt_seq #(
    parameter int BUFFER_BYTES = i2cmt_pkg::BUFFER_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  i2cmt_pkg::t_item    i_item,
    input  logic [7:0]          i_half_ticks,
    input  logic [7:0]          i_buf_data,
    output i2cmt_pkg::t_buf_wr  o_buf_wr,
    output logic [4:0]          o_buf_pos,
    output i2cmt_pkg::t_result  o_res
);
    import i2cmt_pkg::*;

    localparam int LIMIT = (BUFFER_BYTES < INDEX_SPAN) ? BUFFER_BYTES : INDEX_SPAN;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_START,
        PH_DATA_LOW,
        PH_DATA_HIGH,
        PH_ACK_LOW,
        PH_ACK_HIGH,
        PH_STOP_LOW,
        PH_STOP_HIGH
    } t_phase;

    t_phase     r_phase,     n_phase;
    logic [4:0] r_pos,       n_pos;
    logic [3:0] r_bits,      n_bits;
    logic [7:0] r_shift,     n_shift;
    logic [7:0] r_tick,      n_tick;
    logic [4:0] r_len,       n_len;
    logic       r_read_mode, n_read_mode;
    logic       r_nack,      n_nack;
    t_result    r_res,       n_res;

    logic       start_now;
    logic       receiving;
    logic [7:0] half;
    logic [3:0] bits_inc;
    logic [4:0] pos_inc;
    t_action    act;

    assign act       = t_action'(i_item.action);
    assign receiving = r_read_mode && (r_pos != 5'd0);
    assign half      = (i_half_ticks == 8'd0) ? 8'd1 : i_half_ticks;
    assign bits_inc  = r_bits + 4'd1;
    assign pos_inc   = r_pos + 5'd1;
    assign start_now = ((act == ACT_WRITE) || (act == ACT_READ)) && (r_phase == PH_IDLE)
                       && (i_item.transfer_length <= 5'(LIMIT));

    assign o_buf_wr.en   = i_en && (act == ACT_LOAD)
                           && (7'(i_item.buffer_index) < 7'(BUFFER_BYTES));
    assign o_buf_wr.slot = i_item.buffer_index;
    assign o_buf_wr.data = i_item.byte_value;
    assign o_buf_pos     = r_pos;
    assign o_res         = r_res;

    always_comb begin
        n_phase     = r_phase;
        n_pos       = r_pos;
        n_bits      = r_bits;
        n_shift     = r_shift;
        n_tick      = r_tick;
        n_len       = r_len;
        n_read_mode = r_read_mode;
        n_nack      = r_nack;
        n_res       = '0;

        // bus levels of the phase in force for this beat
        n_res.scl_release = 1'b1;
        n_res.sda_release = 1'b1;
        if (start_now) begin
            n_res.sda_release = 1'b0;
        end else begin
            case (r_phase)
                PH_START: begin
                    n_res.sda_release = 1'b0;
                end
                PH_DATA_LOW, PH_DATA_HIGH: begin
                    n_res.scl_release = (r_phase == PH_DATA_HIGH);
                    n_res.sda_release = receiving ? 1'b1 : r_shift[7];
                end
                PH_ACK_LOW, PH_ACK_HIGH: begin
                    n_res.scl_release = (r_phase == PH_ACK_HIGH);
                    // master answers ACK, NACK on the last read byte
                    n_res.sda_release = receiving ? (r_pos >= r_len) : 1'b1;
                end
                PH_STOP_LOW: begin
                    n_res.scl_release = 1'b0;
                    n_res.sda_release = 1'b0;
                end
                PH_STOP_HIGH: begin
                    n_res.sda_release = 1'b0;
                end
                default: begin
                end
            endcase
        end

        if (start_now) begin
            n_read_mode = (act == ACT_READ);
            n_len       = i_item.transfer_length;
            n_pos       = 5'd0;
            n_bits      = 4'd0;
            n_tick      = 8'd0;
            n_nack      = 1'b0;
            n_shift     = {i_item.slave_address, (act == ACT_READ)};
            n_phase     = PH_START;
        end else if ((act == ACT_TICK) && (r_phase != PH_IDLE)) begin
            if (({1'b0, r_tick} + 9'd1) < {1'b0, half}) begin
                n_tick = r_tick + 8'd1;
            end else begin
                n_tick = 8'd0;
                case (r_phase)
                    PH_START: begin
                        n_bits  = 4'd0;
                        n_phase = PH_DATA_LOW;
                    end
                    PH_DATA_LOW: begin
                        n_phase = PH_DATA_HIGH;
                    end
                    PH_DATA_HIGH: begin
                        n_shift = {r_shift[6:0], i_item.sda_sample};
                        if (bits_inc >= 4'(BITS_PER_BYTE)) begin
                            n_bits  = 4'd0;
                            n_phase = PH_ACK_LOW;
                        end else begin
                            n_bits  = bits_inc;
                            n_phase = PH_DATA_LOW;
                        end
                    end
                    PH_ACK_LOW: begin
                        n_phase = PH_ACK_HIGH;
                    end
                    PH_ACK_HIGH: begin
                        if (!receiving && i_item.sda_sample) begin
                            n_nack  = 1'b1;
                            n_phase = PH_STOP_LOW;
                        end else begin
                            if (receiving) begin
                                n_res.read_valid = 1'b1;
                                n_res.read_index = 4'(r_pos - 5'd1);
                                n_res.read_byte  = r_shift;
                            end
                            n_pos = pos_inc;
                            if (pos_inc > r_len) begin
                                n_phase = PH_STOP_LOW;
                            end else begin
                                // next write byte comes from slot pos_inc - 1
                                if (!r_read_mode) begin
                                    n_shift = (7'(r_pos) < 7'(BUFFER_BYTES))
                                              ? i_buf_data : 8'd0;
                                end
                                n_bits  = 4'd0;
                                n_phase = PH_DATA_LOW;
                            end
                        end
                    end
                    PH_STOP_LOW: begin
                        n_phase = PH_STOP_HIGH;
                    end
                    PH_STOP_HIGH: begin
                        n_phase             = PH_IDLE;
                        n_res.transfer_done = 1'b1;
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end

        n_res.busy_res  = (n_phase != PH_IDLE);
        n_res.nack_flag = n_nack;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_pos       <= 5'd0;
            r_bits      <= 4'd0;
            r_shift     <= 8'd0;
            r_tick      <= 8'd0;
            r_len       <= 5'd0;
            r_read_mode <= 1'b0;
            r_nack      <= 1'b0;
        end else if (i_en) begin
            r_phase     <= n_phase;
            r_pos       <= n_pos;
            r_bits      <= n_bits;
            r_shift     <= n_shift;
            r_tick      <= n_tick;
            r_len       <= n_len;
            r_read_mode <= n_read_mode;
            r_nack      <= n_nack;
            r_res       <= n_res;
        end
    end

endmodule

[hdl/i2c_master_transfer.sv]
`timescale 1ns / 1ps

// Channel   Direction  Handshake                  Payload
// --------  ---------  -------------------------  ------------------------------------------
// in        sink       i_in_valid / o_in_stall    i_action, i_buffer_index, i_byte_value,
//                                                 i_slave_address, i_transfer_length,
//                                                 i_sda_sample
// out       source     o_out_valid / i_out_stall  o_scl_release, o_sda_release, o_busy_res,
//                                                 o_transfer_done, o_nack_flag,
//                                                 o_read_valid, o_read_index, o_read_byte
// cfg       sink       i_cfg_wr_en                i_cfg_wr_data (ticks_per_half_bit)
//
// One beat per cycle sustained while the output is not stalled. Each beat passes
// through the input register and then the result register in the sequencer.
// Synchronous active-low reset: sequencer idle, result register empty, half period 16.
// The byte buffer itself is not cleared; a slot must be loaded before a write uses it.
// An output stall holds the result register; the input register still takes one more
// beat, then o_in_stall rises until the result is taken.

module i2c_master_transfer #(
    parameter int BUFFER_BYTES = i2cmt_pkg::BUFFER_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,

    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_action,
    input  logic [3:0] i_buffer_index,
    input  logic [7:0] i_byte_value,
    input  logic [6:0] i_slave_address,
    input  logic [4:0] i_transfer_length,
    input  logic       i_sda_sample,

    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_scl_release,
    output logic       o_sda_release,
    output logic       o_busy_res,
    output logic       o_transfer_done,
    output logic       o_nack_flag,
    output logic       o_read_valid,
    output logic [3:0] o_read_index,
    output logic [7:0] o_read_byte,

    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data
);
    import i2cmt_pkg::*;

    logic       r_in_valid;
    t_item      r_in;
    logic       r_out_valid;
    logic [7:0] r_half_ticks;

    logic       out_free;
    logic       advance;
    logic       in_take;
    t_buf_wr    buf_wr;
    logic [4:0] buf_pos;
    logic [7:0] buf_data;
    t_result    res;

    // result register can take a new beat when empty or being drained
    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_half_ticks <= TICKS_RESET;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_wr_en) begin
                r_half_ticks <= i_cfg_wr_data;
            end
        end
    end

    // input register (payload, no reset)
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.action          <= i_action;
            r_in.buffer_index    <= i_buffer_index;
            r_in.byte_value      <= i_byte_value;
            r_in.slave_address   <= i_slave_address;
            r_in.transfer_length <= i_transfer_length;
            r_in.sda_sample      <= i_sda_sample;
        end
    end

    i2cmt_buffer #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_buffer (
        .i_clk     (i_clk),
        .i_wr      (buf_wr),
        .i_rd_pos  (buf_pos),
        .o_rd_data (buf_data)
    );

    i2cmt_seq #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (advance),
        .i_item       (r_in),
        .i_half_ticks (r_half_ticks),
        .i_buf_data   (buf_data),
        .o_buf_wr     (buf_wr),
        .o_buf_pos    (buf_pos),
        .o_res        (res)
    );

    assign o_out_valid     = r_out_valid;
    assign o_scl_release   = res.scl_release;
    assign o_sda_release   = res.sda_release;
    assign o_busy_res      = res.busy_res;
    assign o_transfer_done = res.transfer_done;
    assign o_nack_flag     = res.nack_flag;
    assign o_read_valid    = res.read_valid;
    assign o_read_index    = res.read_index;
    assign o_read_byte     = res.read_byte;

    // a beat in the input register with room downstream lands in the result register
    a_advance_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("input beat advanced but result register is empty");

    // the end of a transfer leaves the sequencer idle
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && res.transfer_done) |-> !res.busy_res)
        else $error("transfer done while still busy");

    // the beat that ends STOP still shows the STOP high levels
    a_done_stop_levels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && res.transfer_done) |-> (res.scl_release && !res.sda_release))
        else $error("transfer done without STOP bus levels");

    // received bytes arrive only while the transfer is still running
    a_read_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && res.read_valid) |-> (res.busy_res && !res.transfer_done))
        else $error("read byte presented outside a transfer");

endmodule

[test/i2cmt_level_checker.sv]
`timescale 1ns / 1ps

// Watches the beat channels of the I2C master sequencer, keeps its own copy of the
// bus state machine and compares every result beat against the oldest prediction.
module i2cmt_level_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  i2cmt_pkg::t_item    i_item,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  i2cmt_pkg::t_result  i_result,
    input  logic                i_cfg_wr_en,
    input  logic [7:0]          i_cfg_wr_data,
    output logic [31:0]         o_fail_count,
    output logic [31:0]         o_due_count,
    output logic                o_bus_busy,
    output logic                o_ack_due
);

    import i2cmt_pkg::*;

    localparam int XFER_MAX = (BUFFER_BYTES_DEF < INDEX_SPAN) ? BUFFER_BYTES_DEF : INDEX_SPAN;

    typedef enum logic [2:0] {
        BUS_IDLE,
        BUS_START,
        BUS_DATA_LO,
        BUS_DATA_HI,
        BUS_ACK_LO,
        BUS_ACK_HI,
        BUS_STOP_LO,
        BUS_STOP_HI
    } t_bus_phase;

    t_bus_phase  bus_phase;
    logic [7:0]  half_ticks;
    logic [7:0]  tx_bytes [BUFFER_BYTES_DEF];
    logic [4:0]  byte_pos;
    logic [3:0]  bit_cnt;
    logic [7:0]  shreg;
    logic [7:0]  tick_cnt;
    logic [4:0]  xfer_len;
    logic        rd_mode;
    logic        nacked;

    t_result     levels_due [$];
    t_result     want_lv;
    t_result     pred_lv;
    int unsigned fail_count = 0;
    int unsigned due_count  = 0;
    int unsigned results_seen = 0;

    assign o_fail_count = fail_count;
    assign o_due_count  = due_count;
    assign o_bus_busy   = (bus_phase != BUS_IDLE);
    // master releases SDA and listens for the slave's acknowledge
    assign o_ack_due    = (bus_phase == BUS_ACK_LO || bus_phase == BUS_ACK_HI) &&
                          !(rd_mode && byte_pos != 5'd0);

    task automatic report_mismatch(input string msg);
        fail_count++;
        $display("mismatch: %s", msg);
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
            report_mismatch($sformatf("beat %0d %s: want %0h got %0h",
                                      results_seen, name, want, got));
    endtask

    // after an acknowledge: either move on to the next byte or go to STOP
    task automatic next_byte();
        logic [4:0] slot;
        byte_pos = byte_pos + 5'd1;
        if (byte_pos > xfer_len) begin
            bus_phase = BUS_STOP_LO;
        end else begin
            if (!rd_mode) begin
                slot = byte_pos - 5'd1;
                shreg = tx_bytes[slot[3:0]];
            end
            bit_cnt = 4'd0;
            bus_phase = BUS_DATA_LO;
        end
    endtask

    task automatic advance_sequencer(input t_item it, output t_result res);
        int         half;
        logic       rx;
        logic [4:0] pos_m1;
        res = '0;
        if (it.action == ACT_LOAD) begin
            if (it.buffer_index < BUFFER_BYTES_DEF)
                tx_bytes[it.buffer_index] = it.byte_value;
        end else if ((it.action == ACT_WRITE || it.action == ACT_READ) &&
                     bus_phase == BUS_IDLE && it.transfer_length <= XFER_MAX) begin
            rd_mode   = (it.action == ACT_READ);
            xfer_len  = it.transfer_length;
            byte_pos  = 5'd0;
            bit_cnt   = 4'd0;
            tick_cnt  = 8'd0;
            nacked    = 1'b0;
            shreg     = {it.slave_address, rd_mode};
            bus_phase = BUS_START;
        end

        // drive levels of the phase after the command is applied
        rx = rd_mode && byte_pos != 5'd0;
        res.scl_release = 1'b1;
        res.sda_release = 1'b1;
        case (bus_phase)
            BUS_START: res.sda_release = 1'b0;
            BUS_DATA_LO, BUS_DATA_HI: begin
                res.scl_release = (bus_phase == BUS_DATA_HI);
                res.sda_release = rx ? 1'b1 : shreg[7];
            end
            BUS_ACK_LO, BUS_ACK_HI: begin
                res.scl_release = (bus_phase == BUS_ACK_HI);
                if (rx)
                    res.sda_release = (byte_pos >= xfer_len);
            end
            BUS_STOP_LO: begin
                res.scl_release = 1'b0;
                res.sda_release = 1'b0;
            end
            BUS_STOP_HI: res.sda_release = 1'b0;
            default: ;
        endcase

        if (it.action == ACT_TICK && bus_phase != BUS_IDLE) begin
            half = (half_ticks == 8'd0) ? 1 : half_ticks;
            if (tick_cnt + 1 < half) begin
                tick_cnt = tick_cnt + 8'd1;
            end else begin
                tick_cnt = 8'd0;
                case (bus_phase)
                    BUS_START: begin
                        bit_cnt = 4'd0;
                        bus_phase = BUS_DATA_LO;
                    end
                    BUS_DATA_LO: bus_phase = BUS_DATA_HI;
                    BUS_DATA_HI: begin
                        shreg = {shreg[6:0], it.sda_sample};
                        bit_cnt = bit_cnt + 4'd1;
                        if (bit_cnt >= BITS_PER_BYTE) begin
                            bit_cnt = 4'd0;
                            bus_phase = BUS_ACK_LO;
                        end else begin
                            bus_phase = BUS_DATA_LO;
                        end
                    end
                    BUS_ACK_LO: bus_phase = BUS_ACK_HI;
                    BUS_ACK_HI: begin
                        if (rx) begin
                            pos_m1 = byte_pos - 5'd1;
                            res.read_valid = 1'b1;
                            res.read_index = pos_m1[3:0];
                            res.read_byte  = shreg;
                            next_byte();
                        end else if (it.sda_sample) begin
                            nacked = 1'b1;
                            bus_phase = BUS_STOP_LO;
                        end else begin
                            next_byte();
                        end
                    end
                    BUS_STOP_LO: bus_phase = BUS_STOP_HI;
                    BUS_STOP_HI: begin
                        bus_phase = BUS_IDLE;
                        res.transfer_done = 1'b1;
                    end
                    default: bus_phase = BUS_IDLE;
                endcase
            end
        end
        res.busy_res  = (bus_phase != BUS_IDLE);
        res.nack_flag = nacked;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            bus_phase  = BUS_IDLE;
            half_ticks = TICKS_RESET;
            byte_pos   = 5'd0;
            bit_cnt    = 4'd0;
            shreg      = 8'd0;
            tick_cnt   = 8'd0;
            xfer_len   = 5'd0;
            rd_mode    = 1'b0;
            nacked     = 1'b0;
            levels_due.delete();
            due_count  = 0;
        end else begin
            if (i_cfg_wr_en)
                half_ticks = i_cfg_wr_data;
            if (i_out_valid && !i_out_stall) begin
                if (levels_due.size() == 0) begin
                    report_mismatch($sformatf("beat %0d arrived with nothing expected",
                                              results_seen));
                end else begin
                    want_lv = levels_due.pop_front();
                    due_count--;
                    check_field("scl_release", 8'(want_lv.scl_release),
                                8'(i_result.scl_release));
                    check_field("sda_release", 8'(want_lv.sda_release),
                                8'(i_result.sda_release));
                    check_field("busy_res", 8'(want_lv.busy_res),
                                8'(i_result.busy_res));
                    check_field("transfer_done", 8'(want_lv.transfer_done),
                                8'(i_result.transfer_done));
                    check_field("nack_flag", 8'(want_lv.nack_flag),
                                8'(i_result.nack_flag));
                    check_field("read_valid", 8'(want_lv.read_valid),
                                8'(i_result.read_valid));
                    check_field("read_index", 8'(want_lv.read_index),
                                8'(i_result.read_index));
                    check_field("read_byte", want_lv.read_byte, i_result.read_byte);
                end
                results_seen++;
            end
            if (i_in_valid && !i_in_stall) begin
                advance_sequencer(i_item, pred_lv);
                levels_due.push_back(pred_lv);
                due_count++;
            end
        end
    end

endmodule

[test/tb_i2c_master_transfer.sv]
`timescale 1ns / 1ps

// Top of the I2C master sequencer bench: makes the command and tick beats, drives
// the half-period register and the output stall, and gives the verdict. All
// prediction and comparison lives in the level checker beside the block.
module tb_i2c_master_transfer;

    import i2cmt_pkg::*;

    logic        i_clk;
    logic        i_rst_n;

    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_action;
    logic [3:0]  i_buffer_index;
    logic [7:0]  i_byte_value;
    logic [6:0]  i_slave_address;
    logic [4:0]  i_transfer_length;
    logic        i_sda_sample;

    logic        o_out_valid;
    logic        i_out_stall;
    logic        o_scl_release;
    logic        o_sda_release;
    logic        o_busy_res;
    logic        o_transfer_done;
    logic        o_nack_flag;
    logic        o_read_valid;
    logic [3:0]  o_read_index;
    logic [7:0]  o_read_byte;

    logic        i_cfg_wr_en;
    logic [7:0]  i_cfg_wr_data;

    logic [31:0] fail_count;
    logic [31:0] due_count;
    logic        bus_busy;
    logic        ack_due;

    // idle percentages for the sender gaps and the receiver stall
    int          gap_pct   = 30;
    int          stall_pct = 80;
    int          beats_sent = 0;

    i2c_master_transfer u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_action          (i_action),
        .i_buffer_index    (i_buffer_index),
        .i_byte_value      (i_byte_value),
        .i_slave_address   (i_slave_address),
        .i_transfer_length (i_transfer_length),
        .i_sda_sample      (i_sda_sample),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_scl_release     (o_scl_release),
        .o_sda_release     (o_sda_release),
        .o_busy_res        (o_busy_res),
        .o_transfer_done   (o_transfer_done),
        .o_nack_flag       (o_nack_flag),
        .o_read_valid      (o_read_valid),
        .o_read_index      (o_read_index),
        .o_read_byte       (o_read_byte),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data)
    );

    // concatenations follow the field order of the package structs
    i2cmt_level_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_item        ({i_action, i_buffer_index, i_byte_value, i_slave_address,
                         i_transfer_length, i_sda_sample}),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_result      ({o_scl_release, o_sda_release, o_busy_res, o_transfer_done,
                         o_nack_flag, o_read_valid, o_read_index, o_read_byte}),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_fail_count  (fail_count),
        .o_due_count   (due_count),
        .o_bus_busy    (bus_busy),
        .o_ack_due     (ack_due)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // receiver side: stall decided fresh every cycle at the falling edge
    always @(negedge i_clk)
        i_out_stall <= ($urandom_range(99) < stall_pct);

    // guard against a hung handshake; far beyond the slowest correct run
    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // every field random; callers overwrite what the beat is about
    function automatic t_item rand_item();
        t_item it;
        it.action          = ACT_TICK;
        it.buffer_index    = 4'($urandom_range(15));
        it.byte_value      = 8'($urandom_range(255));
        it.slave_address   = 7'($urandom_range(127));
        it.transfer_length = 5'($urandom_range(31));
        it.sda_sample      = 1'($urandom_range(1));
        return it;
    endfunction

    // one beat on the input channel; returns at the falling edge after acceptance
    task automatic send_beat(input t_item it);
        while ($urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        {i_action, i_buffer_index, i_byte_value, i_slave_address,
         i_transfer_length, i_sda_sample} <= it;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        beats_sent++;
        @(negedge i_clk);
    endtask

    task automatic load_slot(input logic [3:0] slot, input logic [7:0] value);
        t_item it;
        it = rand_item();
        it.action       = ACT_LOAD;
        it.buffer_index = slot;
        it.byte_value   = value;
        send_beat(it);
    endtask

    // Register writes only with the block drained: valid low, every result back.
    task automatic set_half(input logic [7:0] value);
        i_in_valid <= 1'b0;
        while (due_count != 0)
            @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    // Start a transfer, then tick until the sequencer is idle again. The bench
    // plays the slave: in an acknowledge window it answers ACK for the first
    // ack_first windows, then NACK with nack_pct chance per tick. Outside of
    // them SDA is random, which is the read data. noise_pct mixes loads and
    // starts into the ticks; starts are dropped while busy, loads land anyway.
    task automatic run_transfer(input logic [1:0] act, input logic [6:0] addr,
                                input logic [4:0] len, input int ack_first,
                                input int nack_pct, input int noise_pct);
        t_item it;
        int    acks_seen;
        logic  in_ack;
        acks_seen = 0;
        in_ack    = 1'b0;
        it = rand_item();
        it.action          = act;
        it.slave_address   = addr;
        it.transfer_length = len;
        send_beat(it);
        while (bus_busy) begin
            if (ack_due && !in_ack)
                acks_seen++;
            in_ack = ack_due;
            it = rand_item();
            if ($urandom_range(99) < noise_pct) begin
                it.action = 2'($urandom_range(1, 3));
            end else if (ack_due) begin
                it.sda_sample = (acks_seen > ack_first) && ($urandom_range(99) < nack_pct);
            end
            send_beat(it);
        end
    endtask

    task automatic random_phase(input int budget);
        int         stop_at;
        int         r;
        logic [4:0] len;
        t_item      it;
        stop_at = beats_sent + budget;
        while (beats_sent < stop_at) begin
            r = $urandom_range(99);
            if (r < 70) begin
                // mostly short transfers so many of them fit, now and then a long one
                len = 5'(($urandom_range(99) < 80) ? $urandom_range(3) : $urandom_range(16));
                run_transfer($urandom_range(1) ? ACT_READ : ACT_WRITE,
                             7'($urandom_range(127)), len, $urandom_range(2),
                             ($urandom_range(3) == 0) ? 40 : 2, 5);
            end else if (r < 82) begin
                load_slot(4'($urandom_range(15)), 8'($urandom_range(255)));
            end else if (r < 90) begin
                // oversized length: the start is dropped
                run_transfer($urandom_range(1) ? ACT_READ : ACT_WRITE,
                             7'($urandom_range(127)), 5'($urandom_range(17, 31)),
                             0, 0, 0);
            end else begin
                it = rand_item();
                send_beat(it);
            end
        end
    endtask

    initial begin
        i_rst_n           = 1'b0;
        i_in_valid        = 1'b0;
        i_action          = ACT_TICK;
        i_buffer_index    = '0;
        i_byte_value      = '0;
        i_slave_address   = '0;
        i_transfer_length = '0;
        i_sda_sample      = 1'b0;
        i_cfg_wr_en       = 1'b0;
        i_cfg_wr_data     = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part. Fill every slot first so no write ever reads an
        // unloaded one; slot 0 and 1 hold the byte extremes.
        for (int s = 0; s < BUFFER_BYTES_DEF; s++)
            load_slot(4'(s), (s == 0) ? 8'h00 : (s == 1) ? 8'hFF : 8'($urandom_range(255)));
        // zero length at the reset half period: address + ack, then STOP
        run_transfer(ACT_WRITE, 7'h7F, 5'd0, 0, 0, 0);
        set_half(8'd1);
        run_transfer(ACT_WRITE, 7'h00, 5'd16, 99, 0, 0);   // full buffer, all ACK
        run_transfer(ACT_READ,  7'h2A, 5'd16, 0, 0, 0);    // last read byte gets NACK
        run_transfer(ACT_READ,  7'h55, 5'd1, 0, 100, 0);   // read address NACKed
        run_transfer(ACT_WRITE, 7'h33, 5'd3, 1, 100, 0);   // NACK on first data byte
        run_transfer(ACT_WRITE, 7'h01, 5'd17, 0, 0, 0);    // length just over the limit
        run_transfer(ACT_READ,  7'h40, 5'd31, 0, 0, 0);
        // starts and loads thrown in while the bus is busy
        run_transfer(ACT_WRITE, 7'h15, 5'd4, 99, 0, 30);

        // random part: sender idles lightly, receiver heavily
        random_phase(160);

        // roles swapped; half period 0 behaves as 1
        gap_pct   = 80;
        stall_pct = 30;
        set_half(8'd0);
        random_phase(160);

        // no idling at all
        gap_pct   = 0;
        stall_pct = 0;
        set_half(8'd2);
        random_phase(140);

        i_in_valid <= 1'b0;
        while (due_count != 0)
            @(negedge i_clk);
        // keep waiting to catch any stray result beat
        repeat (8) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
